// ===== hdl/tdpg_pkg.sv =====
package tdpg_pkg;

    localparam int MAX_PRIMES  = 1024;
    localparam int VAL_W       = 16;
    localparam int CAND_W      = VAL_W + 1;
    localparam int CNT_W       = 11;
    localparam int IDX_W       = 10;
    localparam int ADDR_W      = $clog2(MAX_PRIMES);
    localparam int DIV_STAGES  = VAL_W;
    localparam int FIRST_PRIME = 2;
    localparam int FIRST_ODD   = 3;

    typedef struct packed {
        logic             valid;
        logic [VAL_W-1:0] rem;
        logic [VAL_W-1:0] num;
        logic [VAL_W-1:0] div;
    } t_div_beat;

endpackage

// ===== hdl/tdpg_ram.sv =====
module tdpg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/tdpg_cell.sv =====
module tdpg_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tdpg_pkg::t_div_beat i_beat,
    output tdpg_pkg::t_div_beat o_beat
);

    logic [tdpg_pkg::VAL_W:0] w_trial;
    logic [tdpg_pkg::VAL_W:0] w_diff;
    logic                     w_ge;
    tdpg_pkg::t_div_beat      r_beat;

    // One restoring division step: bring down the next dividend bit.
    assign w_trial = {i_beat.rem, i_beat.num[tdpg_pkg::VAL_W-1]};
    assign w_diff  = w_trial - {1'b0, i_beat.div};
    assign w_ge    = w_trial >= {1'b0, i_beat.div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else begin
            r_beat.valid <= i_beat.valid;
            r_beat.rem   <= w_ge ? w_diff[tdpg_pkg::VAL_W-1:0]
                                 : w_trial[tdpg_pkg::VAL_W-1:0];
            r_beat.num   <= {i_beat.num[tdpg_pkg::VAL_W-2:0], 1'b0};
            r_beat.div   <= i_beat.div;
        end
    end

    assign o_beat = r_beat;

endmodule

// ===== hdl/trial_division_prime_generator.sv =====
// A request served without a search shows its beat in the cycle after it is accepted.
// A search sends each stored prime, per candidate, through the table read and the 16-cell
// remainder chain, then lets it drain (a divisor halts the reads as it leaves the chain);
// the beat is registered as the last candidate finishes, and busy falls as it appears.
// Reset is synchronous and active low: it marks the table empty, restores the count to 1024.
// One request is served at a time and the receiver cannot stall: each beat lasts one cycle.
module trial_division_prime_generator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_restart,
    input  logic                          i_prime_count_we,
    input  logic [tdpg_pkg::CNT_W-1:0]    i_prime_count,
    output logic                          o_strobe,
    output logic [tdpg_pkg::VAL_W-1:0]    o_prime_value,
    output logic [tdpg_pkg::IDX_W-1:0]    o_prime_index,
    output logic                          o_valid_res,
    output logic                          o_done_res
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state                          r_state;
    logic [tdpg_pkg::CNT_W-1:0]      r_prime_count;
    logic [tdpg_pkg::CNT_W-1:0]      r_found;
    logic [tdpg_pkg::CAND_W-1:0]     r_cand;
    logic [tdpg_pkg::CNT_W-1:0]      r_issue_idx;
    logic                            r_rd_valid;
    logic                            r_hit;
    logic                            r_strobe;
    logic [tdpg_pkg::VAL_W-1:0]      r_prime_value;
    logic [tdpg_pkg::IDX_W-1:0]      r_prime_index;
    logic                            r_valid_res;
    logic                            r_done_res;

    logic [tdpg_pkg::CNT_W-1:0]      w_target;
    logic                            w_accept;
    logic [tdpg_pkg::CNT_W-1:0]      w_found_eff;
    logic [tdpg_pkg::CAND_W-1:0]     w_cand_eff;
    logic [tdpg_pkg::CNT_W-1:0]      w_found_inc;
    logic [tdpg_pkg::CAND_W-1:0]     w_cand_inc;
    logic                            w_serve_first;
    logic                            w_issuing;
    logic                            w_in_flight;
    logic                            w_finish;
    logic                            w_divisible;
    logic                            w_ram_we;
    logic [tdpg_pkg::ADDR_W-1:0]     w_ram_waddr;
    logic [tdpg_pkg::VAL_W-1:0]      w_ram_wdata;
    logic [tdpg_pkg::VAL_W-1:0]      w_ram_rdata;
    tdpg_pkg::t_div_beat             w_beat [tdpg_pkg::DIV_STAGES+1];

    always_comb begin
        if (r_prime_count == '0) begin
            w_target = tdpg_pkg::CNT_W'(1);
        end else if (r_prime_count > tdpg_pkg::CNT_W'(tdpg_pkg::MAX_PRIMES)) begin
            w_target = tdpg_pkg::CNT_W'(tdpg_pkg::MAX_PRIMES);
        end else begin
            w_target = r_prime_count;
        end
    end

    assign w_accept      = start && (r_state == S_IDLE);
    assign w_found_eff   = i_restart ? '0 : r_found;
    assign w_cand_eff    = i_restart ? tdpg_pkg::CAND_W'(tdpg_pkg::FIRST_ODD) : r_cand;
    assign w_found_inc   = r_found + tdpg_pkg::CNT_W'(1);
    assign w_cand_inc    = r_cand + tdpg_pkg::CAND_W'(1);
    assign w_serve_first = w_accept && (w_found_eff < w_target) && (w_found_eff == '0);
    assign w_issuing     = (r_state == S_SCAN) && (r_issue_idx < r_found) && !r_hit;

    always_comb begin
        w_in_flight = 1'b0;
        for (int k = 0; k <= tdpg_pkg::DIV_STAGES; k++) begin
            w_in_flight = w_in_flight | w_beat[k].valid;
        end
    end

    assign w_finish    = (r_state == S_SCAN) && !w_issuing && !w_in_flight;
    assign w_divisible = w_beat[tdpg_pkg::DIV_STAGES].valid
                         && (w_beat[tdpg_pkg::DIV_STAGES].rem == '0)
                         && (w_beat[tdpg_pkg::DIV_STAGES].div != '0);

    assign w_ram_we    = w_serve_first || (w_finish && !r_hit);
    assign w_ram_waddr = w_serve_first ? '0 : r_found[tdpg_pkg::ADDR_W-1:0];
    assign w_ram_wdata = w_serve_first ? tdpg_pkg::VAL_W'(tdpg_pkg::FIRST_PRIME)
                                       : r_cand[tdpg_pkg::VAL_W-1:0];

    tdpg_ram #(
        .WIDTH (tdpg_pkg::VAL_W),
        .DEPTH (tdpg_pkg::MAX_PRIMES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_issue_idx[tdpg_pkg::ADDR_W-1:0]),
        .o_rdata (w_ram_rdata)
    );

    assign w_beat[0].valid = r_rd_valid;
    assign w_beat[0].rem   = '0;
    assign w_beat[0].num   = r_cand[tdpg_pkg::VAL_W-1:0];
    assign w_beat[0].div   = w_ram_rdata;

    for (genvar g = 0; g < tdpg_pkg::DIV_STAGES; g++) begin : g_chain
        tdpg_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_beat  (w_beat[g]),
            .o_beat  (w_beat[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_prime_count <= tdpg_pkg::CNT_W'(tdpg_pkg::MAX_PRIMES);
            r_found       <= '0;
            r_cand        <= tdpg_pkg::CAND_W'(tdpg_pkg::FIRST_ODD);
            r_issue_idx   <= '0;
            r_rd_valid    <= 1'b0;
            r_hit         <= 1'b0;
            r_strobe      <= 1'b0;
        end else begin
            r_strobe   <= 1'b0;
            r_rd_valid <= w_issuing;
            if (i_prime_count_we) begin
                r_prime_count <= i_prime_count;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_found <= w_found_eff;
                        r_cand  <= w_cand_eff;
                        if (w_found_eff >= w_target) begin
                            r_strobe      <= 1'b1;
                            r_prime_value <= '0;
                            r_prime_index <= '0;
                            r_valid_res   <= 1'b0;
                            r_done_res    <= 1'b1;
                        end else if (w_found_eff == '0) begin
                            r_found       <= tdpg_pkg::CNT_W'(1);
                            r_strobe      <= 1'b1;
                            r_prime_value <= tdpg_pkg::VAL_W'(tdpg_pkg::FIRST_PRIME);
                            r_prime_index <= '0;
                            r_valid_res   <= 1'b1;
                            r_done_res    <= (w_target == tdpg_pkg::CNT_W'(1))
                                             || w_cand_eff[tdpg_pkg::VAL_W];
                        end else if (w_cand_eff[tdpg_pkg::VAL_W]) begin
                            r_strobe      <= 1'b1;
                            r_prime_value <= '0;
                            r_prime_index <= '0;
                            r_valid_res   <= 1'b0;
                            r_done_res    <= 1'b1;
                        end else begin
                            r_issue_idx <= '0;
                            r_hit       <= 1'b0;
                            r_state     <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_issuing) begin
                        r_issue_idx <= r_issue_idx + tdpg_pkg::CNT_W'(1);
                    end
                    if (w_divisible) begin
                        r_hit <= 1'b1;
                    end
                    if (w_finish) begin
                        r_cand <= w_cand_inc;
                        if (!r_hit) begin
                            r_found       <= w_found_inc;
                            r_strobe      <= 1'b1;
                            r_prime_value <= r_cand[tdpg_pkg::VAL_W-1:0];
                            r_prime_index <= r_found[tdpg_pkg::IDX_W-1:0];
                            r_valid_res   <= 1'b1;
                            r_done_res    <= (w_found_inc >= w_target)
                                             || w_cand_inc[tdpg_pkg::VAL_W];
                            r_state       <= S_IDLE;
                        end else if (w_cand_inc[tdpg_pkg::VAL_W]) begin
                            r_strobe      <= 1'b1;
                            r_prime_value <= '0;
                            r_prime_index <= '0;
                            r_valid_res   <= 1'b0;
                            r_done_res    <= 1'b1;
                            r_state       <= S_IDLE;
                        end else begin
                            r_issue_idx <= '0;
                            r_hit       <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_prime_value = r_prime_value;
    assign o_prime_index = r_prime_index;
    assign o_valid_res   = r_valid_res;
    assign o_done_res    = r_done_res;

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("Result beat shown while a request is still being served.");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("Accepted request neither searched nor answered.");

    a_no_prime_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_valid_res) |-> (o_prime_value == '0 && o_prime_index == '0))
        else $error("Beat without a prime carries a non-zero value or index.");

    a_prime_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_valid_res) |-> (o_prime_value >= tdpg_pkg::VAL_W'(tdpg_pkg::FIRST_PRIME)))
        else $error("Reported prime is below two.");

    a_found_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found <= tdpg_pkg::CNT_W'(tdpg_pkg::MAX_PRIMES))
        else $error("Prime count has run past the table size.");

endmodule
